// File: rtl/gspe_pkg.sv
// shared types and constants of the shortest-path engine
`timescale 1ns / 1ps
package gspe_pkg;

	localparam int NODE_COUNT = 32;
	localparam int IDX_W      = 5;
	localparam int LINK_W     = 6;
	localparam int MAX_DEGREE = 4;
	localparam int DEG_W      = 2;
	localparam int COORD_BITS = 17;
	localparam int DIST_W     = 24;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int RAD_W      = 2 * COORD_BITS + 2;
	localparam int ROOT_W     = COORD_BITS + 1;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 8;

	localparam logic [DIST_W-1:0] INF_DIST = {DIST_W{1'b1}};

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LINK_W-1:0]     link_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_W-1:0]     dist_t;
	typedef logic [SQ_W-1:0]       sq_t;
	typedef logic [RAD_W-1:0]      rad_t;
	typedef logic [ROOT_W-1:0]     root_t;

	// one stored node: links above the coordinates
	typedef struct packed {
		logic [MAX_DEGREE-1:0][LINK_W-1:0] links;
		coord_t                            y;
		coord_t                            x;
	} node_t;

	// distance plus edge length, clipped at infinity
	function automatic dist_t sat_add(input dist_t a, input root_t w);
		logic [DIST_W:0] s;
		begin
			s = {1'b0, a} + (DIST_W + 1)'(w);
			sat_add = (s >= (DIST_W + 1)'(INF_DIST)) ? INF_DIST : s[DIST_W-1:0];
		end
	endfunction

endpackage

// File: rtl/gspe_isqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module gspe_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gspe_pkg::rad_t     radicand,
	output logic               done,
	output gspe_pkg::root_t    root
);

	gspe_pkg::rad_t op_q, res_q, one_q;
	logic busy_q, done_q;
	gspe_pkg::rad_t trial;

	assign trial = res_q + one_q;
	assign done  = done_q;
	assign root  = res_q[gspe_pkg::ROOT_W-1:0];

	// restoring digit recurrence over pairs of radicand bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			res_q  <= '0;
			one_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= radicand;
				res_q  <= '0;
				one_q  <= gspe_pkg::rad_t'(1) << (gspe_pkg::RAD_W - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (op_q >= trial) begin
					op_q  <= op_q - trial;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
				if (one_q == gspe_pkg::rad_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/graph_shortest_path_engine_core.sv
// top level of the shortest-path engine: node memories, search sequencer, result register
//
// channel  dir  tdata bits (low first)                              tuser / tlast
// s_axis   in   node_index 5, pos_x 17, pos_y 17, link_a..d 6 each,  tuser: action
//               source_node 5, target_node 5, zero pad to 80
// m_axis   out  hop_node 5, zero pad to 8                           tuser: unreachable, tlast: last_hop
//
// a load request is written straight into the node memory; a query first sweeps the distance memory,
// then per settled node reads it, passes each neighbour link through the square root unit,
// skips each empty link, and scans all 32 distances; backtracking reads the links again
// at each path hop to pick the cheapest predecessor.
// arst_n clears the sequencer, visited flags and result register; memories are not cleared.
// input is taken only while the sequencer is idle; a stalled result holds the sequencer.
`timescale 1ns / 1ps
module graph_shortest_path_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gspe_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // node_index .. target_node
	input  logic                              s_axis_tuser,  // action
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [gspe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // hop_node
	output logic                              m_axis_tlast,  // last_hop
	output logic                              m_axis_tuser   // unreachable
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_QSTART, ST_INIT, ST_BASE_RD, ST_BASE_W, ST_EDGE_RD, ST_EDGE_SQ,
		ST_EDGE_SUM, ST_EDGE_SQRT, ST_EDGE_USE, ST_SCAN, ST_SCAN_END, ST_CHECK_RD,
		ST_CHECK_W, ST_BT_TOP, ST_BT_PUSH, ST_EMIT_RD, ST_EMIT_WR, ST_ERR
	} state_t;

	state_t state_q;

	// request fields
	gspe_pkg::idx_t   in_index, in_src, in_dst;
	gspe_pkg::node_t  in_node;
	logic             in_acc;
	assign in_index      = s_axis_tdata[4:0];
	assign in_node.x     = s_axis_tdata[21:5];
	assign in_node.y     = s_axis_tdata[38:22];
	assign in_node.links = s_axis_tdata[62:39];
	assign in_src        = s_axis_tdata[67:63];
	assign in_dst        = s_axis_tdata[72:68];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// search registers
	gspe_pkg::idx_t   src_q, dst_q, cur_q, nb_q, best_idx_q, sidx_s1, emit_i_q;
	gspe_pkg::dist_t  curd_q, dnb_q, bestd_q;
	gspe_pkg::coord_t bx_q, by_q;
	gspe_pkg::sq_t    sqx_s1, sqy_s1;
	logic [gspe_pkg::MAX_DEGREE-1:0][gspe_pkg::LINK_W-1:0] links_q;
	logic [gspe_pkg::DEG_W-1:0] k_q;
	logic [gspe_pkg::IDX_W:0]   scan_i_q, depth_q;
	logic [gspe_pkg::NODE_COUNT-1:0] visited_q;
	logic bt_q, found_q, sv_s1;
	logic out_valid_q, out_last_q, out_err_q;
	gspe_pkg::idx_t out_node_q;

	// memories
	gspe_pkg::node_t node_mem [gspe_pkg::NODE_COUNT];
	gspe_pkg::dist_t dist_mem [gspe_pkg::NODE_COUNT];
	gspe_pkg::idx_t  stack_mem [gspe_pkg::NODE_COUNT];
	gspe_pkg::node_t node_rd_q;
	gspe_pkg::dist_t dist_rd_q;
	gspe_pkg::idx_t  stack_rd_q;
	gspe_pkg::idx_t  node_ra, dist_ra, dist_wa, stack_wa, stack_wd;
	gspe_pkg::dist_t dist_wd;
	logic            dist_we, stack_we;

	// edge arithmetic
	gspe_pkg::link_t  cur_link;
	gspe_pkg::coord_t dx, dy;
	gspe_pkg::root_t  sq_root;
	gspe_pkg::dist_t  cand, bsum;
	logic             sqrt_start, sqrt_done, out_free;

	assign cur_link   = links_q[k_q];
	assign dx = (bx_q > node_rd_q.x) ? bx_q - node_rd_q.x : node_rd_q.x - bx_q;
	assign dy = (by_q > node_rd_q.y) ? by_q - node_rd_q.y : node_rd_q.y - by_q;
	assign sqrt_start = (state_q == ST_EDGE_SUM);
	assign cand       = gspe_pkg::sat_add(curd_q, sq_root);
	assign bsum       = gspe_pkg::sat_add(dnb_q, sq_root);
	assign out_free   = !out_valid_q || m_axis_tready;

	gspe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (gspe_pkg::rad_t'(sqx_s1) + gspe_pkg::rad_t'(sqy_s1)),
		.done     (sqrt_done),
		.root     (sq_root)
	);

	// memory addressing
	always_comb begin
		node_ra  = (state_q == ST_EDGE_RD) ? cur_link[gspe_pkg::IDX_W-1:0] : cur_q;
		case (state_q)
			ST_SCAN:     dist_ra = scan_i_q[gspe_pkg::IDX_W-1:0];
			ST_CHECK_RD: dist_ra = dst_q;
			default:     dist_ra = cur_link[gspe_pkg::IDX_W-1:0];
		endcase
		dist_we  = (state_q == ST_INIT) || (state_q == ST_EDGE_USE && !bt_q && cand < dnb_q);
		dist_wa  = (state_q == ST_INIT) ? scan_i_q[gspe_pkg::IDX_W-1:0] : nb_q;
		if (state_q == ST_INIT)
			dist_wd = (scan_i_q[gspe_pkg::IDX_W-1:0] == src_q) ? '0 : gspe_pkg::INF_DIST;
		else
			dist_wd = cand;
		stack_we = (state_q == ST_CHECK_W && dist_rd_q != gspe_pkg::INF_DIST) ||
		           (state_q == ST_BT_PUSH && found_q && !depth_q[gspe_pkg::IDX_W]);
		stack_wa = (state_q == ST_CHECK_W) ? '0 : depth_q[gspe_pkg::IDX_W-1:0];
		stack_wd = (state_q == ST_CHECK_W) ? dst_q : best_idx_q;
	end

	// node store
	always_ff @(posedge clk) begin
		if (in_acc && !s_axis_tuser)
			node_mem[in_index] <= in_node;
		node_rd_q <= node_mem[node_ra];
	end

	// distance store
	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_wa] <= dist_wd;
		dist_rd_q <= dist_mem[dist_ra];
	end

	// backtrack stack
	always_ff @(posedge clk) begin
		if (stack_we)
			stack_mem[stack_wa] <= stack_wd;
		stack_rd_q <= stack_mem[emit_i_q];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			src_q       <= '0;
			dst_q       <= '0;
			cur_q       <= '0;
			nb_q        <= '0;
			best_idx_q  <= '0;
			sidx_s1     <= '0;
			emit_i_q    <= '0;
			curd_q      <= '0;
			dnb_q       <= '0;
			bestd_q     <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			sqx_s1      <= '0;
			sqy_s1      <= '0;
			links_q     <= '0;
			k_q         <= '0;
			scan_i_q    <= '0;
			depth_q     <= '0;
			visited_q   <= '0;
			bt_q        <= 1'b0;
			found_q     <= 1'b0;
			sv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
			out_node_q  <= '0;
		end else begin
			if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser) begin
						src_q   <= in_src;
						dst_q   <= in_dst;
						state_q <= ST_QSTART;
					end
				end
				ST_QSTART: begin
					scan_i_q <= '0;
					state_q  <= (src_q == dst_q) ? ST_IDLE : ST_INIT;
				end
				// distance sweep, source set to zero
				ST_INIT: begin
					scan_i_q <= scan_i_q + 1'b1;
					if (scan_i_q[gspe_pkg::IDX_W-1:0] == gspe_pkg::idx_t'(gspe_pkg::NODE_COUNT - 1)) begin
						visited_q <= '0;
						cur_q     <= src_q;
						curd_q    <= '0;
						bt_q      <= 1'b0;
						state_q   <= ST_BASE_RD;
					end
				end
				ST_BASE_RD: begin
					if (!bt_q)
						visited_q[cur_q] <= 1'b1;
					state_q <= ST_BASE_W;
				end
				ST_BASE_W: begin
					links_q <= node_rd_q.links;
					bx_q    <= node_rd_q.x;
					by_q    <= node_rd_q.y;
					k_q     <= '0;
					state_q <= ST_EDGE_RD;
				end
				ST_EDGE_RD: begin
					if (cur_link[gspe_pkg::IDX_W]) begin
						if (k_q == gspe_pkg::DEG_W'(gspe_pkg::MAX_DEGREE - 1)) begin
							bestd_q  <= bt_q ? bestd_q : gspe_pkg::INF_DIST;
							found_q  <= bt_q ? found_q : 1'b0;
							scan_i_q <= '0;
							sv_s1    <= 1'b0;
							state_q  <= bt_q ? ST_BT_PUSH : ST_SCAN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						nb_q    <= cur_link[gspe_pkg::IDX_W-1:0];
						state_q <= ST_EDGE_SQ;
					end
				end
				ST_EDGE_SQ: begin
					sqx_s1  <= gspe_pkg::sq_t'(dx) * gspe_pkg::sq_t'(dx);
					sqy_s1  <= gspe_pkg::sq_t'(dy) * gspe_pkg::sq_t'(dy);
					dnb_q   <= dist_rd_q;
					state_q <= ST_EDGE_SUM;
				end
				ST_EDGE_SUM: begin
					state_q <= ST_EDGE_SQRT;
				end
				ST_EDGE_SQRT: begin
					if (sqrt_done)
						state_q <= ST_EDGE_USE;
				end
				// relax or pick the cheapest predecessor, then next link
				ST_EDGE_USE: begin
					if (bt_q && bsum < bestd_q) begin
						bestd_q    <= bsum;
						best_idx_q <= nb_q;
						found_q    <= 1'b1;
					end
					if (k_q == gspe_pkg::DEG_W'(gspe_pkg::MAX_DEGREE - 1)) begin
						if (!bt_q) begin
							bestd_q  <= gspe_pkg::INF_DIST;
							found_q  <= 1'b0;
							scan_i_q <= '0;
							sv_s1    <= 1'b0;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_BT_PUSH;
						end
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_EDGE_RD;
					end
				end
				// pipelined scan for the nearest unvisited node
				ST_SCAN: begin
					sv_s1   <= !scan_i_q[gspe_pkg::IDX_W];
					sidx_s1 <= scan_i_q[gspe_pkg::IDX_W-1:0];
					if (sv_s1 && !visited_q[sidx_s1] && dist_rd_q < bestd_q) begin
						bestd_q    <= dist_rd_q;
						best_idx_q <= sidx_s1;
						found_q    <= 1'b1;
					end
					if (scan_i_q[gspe_pkg::IDX_W])
						state_q <= ST_SCAN_END;
					else
						scan_i_q <= scan_i_q + 1'b1;
				end
				ST_SCAN_END: begin
					if (found_q) begin
						cur_q   <= best_idx_q;
						curd_q  <= bestd_q;
						state_q <= ST_BASE_RD;
					end else begin
						state_q <= ST_CHECK_RD;
					end
				end
				ST_CHECK_RD: begin
					state_q <= ST_CHECK_W;
				end
				ST_CHECK_W: begin
					if (dist_rd_q == gspe_pkg::INF_DIST) begin
						state_q <= ST_ERR;
					end else begin
						depth_q <= (gspe_pkg::IDX_W + 1)'(1);
						cur_q   <= dst_q;
						bt_q    <= 1'b1;
						state_q <= ST_BT_TOP;
					end
				end
				ST_BT_TOP: begin
					if (cur_q == src_q) begin
						emit_i_q <= gspe_pkg::idx_t'(depth_q - 2'd2);
						state_q  <= ST_EMIT_RD;
					end else begin
						bestd_q <= gspe_pkg::INF_DIST;
						found_q <= 1'b0;
						state_q <= ST_BASE_RD;
					end
				end
				ST_BT_PUSH: begin
					if (!found_q || depth_q[gspe_pkg::IDX_W]) begin
						state_q <= ST_ERR;
					end else begin
						depth_q <= depth_q + 1'b1;
						cur_q   <= best_idx_q;
						state_q <= ST_BT_TOP;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_node_q  <= stack_rd_q;
						out_last_q  <= (emit_i_q == '0);
						out_err_q   <= 1'b0;
						if (emit_i_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							emit_i_q <= emit_i_q - 1'b1;
							state_q  <= ST_EMIT_RD;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_node_q  <= '0;
						out_last_q  <= 1'b1;
						out_err_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(gspe_pkg::OUT_DATA_W - gspe_pkg::IDX_W){1'b0}}, out_node_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

endmodule

// File: rtl/gspe_checker.sv
// port-level checks of the shortest-path engine, bound to the top level
`timescale 1ns / 1ps
module gspe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [gspe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [gspe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic                            m_axis_tuser
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	// an error result is a single flagged zero hop
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("malformed unreachable result");

	// a query request closes the input for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("input open right after a query");

	// a load request creates no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result after a load request");

endmodule

bind graph_shortest_path_engine_core gspe_checker u_gspe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_graph_shortest_path_engine_core.sv
// self-checking testbench for the shortest-path engine core
`timescale 1ns / 1ps

// expected hop stream, with its own copy of the node tables
class path_scoreboard;
	typedef struct {
		logic [4:0] hop;
		logic       last;
		logic       unr;
	} hop_res_t;

	logic [gspe_pkg::COORD_BITS-1:0] pos_x_tab [gspe_pkg::NODE_COUNT];
	logic [gspe_pkg::COORD_BITS-1:0] pos_y_tab [gspe_pkg::NODE_COUNT];
	logic [gspe_pkg::LINK_W-1:0]     link_tab  [gspe_pkg::NODE_COUNT][gspe_pkg::MAX_DEGREE];
	logic [gspe_pkg::DIST_W-1:0]     dist_tab  [gspe_pkg::NODE_COUNT];
	bit                              seen      [gspe_pkg::NODE_COUNT];
	hop_res_t                        pending_hops[$];
	int                              errors;
	int                              queries;
	int                              hops_checked;

	function new();
		errors = 0;
		queries = 0;
		hops_checked = 0;
	endfunction

	// exact integer square root, floored
	function longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function logic [23:0] edge_len(input int a, input int b);
		longint unsigned dx, dy, d;
		dx = pos_x_tab[a] > pos_x_tab[b] ? pos_x_tab[a] - pos_x_tab[b] : pos_x_tab[b] - pos_x_tab[a];
		dy = pos_y_tab[a] > pos_y_tab[b] ? pos_y_tab[a] - pos_y_tab[b] : pos_y_tab[b] - pos_y_tab[a];
		d = int_sqrt(dx * dx + dy * dy);
		return d >= gspe_pkg::INF_DIST ? gspe_pkg::INF_DIST : d[23:0];
	endfunction

	function logic [23:0] clip_add(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s >= {1'b0, gspe_pkg::INF_DIST} ? gspe_pkg::INF_DIST : s[23:0];
	endfunction

	// append one expected result at the tail
	function void queue_hop(input hop_res_t r);
		pending_hops.insert(pending_hops.size(), r);
	endfunction

	function void push_error();
		hop_res_t r;
		r.hop = '0;
		r.last = 1'b1;
		r.unr = 1'b1;
		queue_hop(r);
	endfunction

	// settle nodes nearest first, lowest index on ties
	function void settle_all(input int src);
		int cur, nb;
		logic [23:0] cand, bestd;
		bit found;
		for (int i = 0; i < gspe_pkg::NODE_COUNT; i++) begin
			dist_tab[i] = gspe_pkg::INF_DIST;
			seen[i] = 0;
		end
		dist_tab[src] = 0;
		cur = src;
		found = 1;
		while (found) begin
			seen[cur] = 1;
			for (int k = 0; k < gspe_pkg::MAX_DEGREE; k++) begin
				nb = link_tab[cur][k];
				if (nb < gspe_pkg::NODE_COUNT) begin
					cand = clip_add(dist_tab[cur], edge_len(cur, nb));
					if (cand < dist_tab[nb])
						dist_tab[nb] = cand;
				end
			end
			found = 0;
			bestd = gspe_pkg::INF_DIST;
			for (int i = 0; i < gspe_pkg::NODE_COUNT; i++) begin
				if (!seen[i] && dist_tab[i] < bestd) begin
					bestd = dist_tab[i];
					cur = i;
					found = 1;
				end
			end
		end
	endfunction

	// note one accepted request and work out its hops
	function void note_request(input logic action, input logic [79:0] d);
		int src, dst, depth, top, pick, nb;
		int chain[$];
		logic [23:0] bestd, s;
		hop_res_t r;
		if (!action) begin
			pos_x_tab[d[4:0]] = d[21:5];
			pos_y_tab[d[4:0]] = d[38:22];
			for (int k = 0; k < 4; k++)
				link_tab[d[4:0]][k] = d[39 + 6*k +: 6];
			return;
		end
		queries++;
		src = d[67:63];
		dst = d[72:68];
		if (src == dst)
			return;
		settle_all(src);
		if (dist_tab[dst] >= gspe_pkg::INF_DIST) begin
			push_error();
			return;
		end
		// walk back from the target
		chain.insert(chain.size(), dst);
		while (chain[$] != src) begin
			top = chain[$];
			bestd = gspe_pkg::INF_DIST;
			pick = -1;
			for (int k = 0; k < gspe_pkg::MAX_DEGREE; k++) begin
				nb = link_tab[top][k];
				if (nb < gspe_pkg::NODE_COUNT) begin
					s = clip_add(dist_tab[nb], edge_len(top, nb));
					if (s < bestd) begin
						bestd = s;
						pick = nb;
					end
				end
			end
			if (pick < 0 || chain.size() >= gspe_pkg::NODE_COUNT) begin
				push_error();
				return;
			end
			chain.insert(chain.size(), pick);
		end
		depth = chain.size() - 1;
		while (depth > 0) begin
			depth--;
			r.hop = 5'(chain[depth]);
			r.last = (depth == 0);
			r.unr = 1'b0;
			queue_hop(r);
		end
	endfunction

	// compare one accepted result with the oldest expectation
	function void check_result(input logic [7:0] data, input logic last, input logic unr);
		hop_res_t e;
		if (pending_hops.size() == 0) begin
			$display("%0t unexpected result: hop %0d last %0b unreachable %0b",
				$time, data, last, unr);
			errors++;
			return;
		end
		e = pending_hops.pop_front();
		hops_checked++;
		if (data !== {3'b000, e.hop}) begin
			$display("%0t hop_node mismatch: expected %0d actual %0d", $time, e.hop, data);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t last_hop mismatch: expected %0b actual %0b", $time, e.last, last);
			errors++;
		end
		if (unr !== e.unr) begin
			$display("%0t unreachable mismatch: expected %0b actual %0b", $time, e.unr, unr);
			errors++;
		end
	endfunction
endclass

module tb_graph_shortest_path_engine_core;
	localparam int WATCHDOG_LIMIT = 300000;
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	int tx_idle_pct = 24;
	int rx_idle_pct = 62;
	int quiet_cycles = 0;
	int loads_sent = 0;

	path_scoreboard sb = new();

	graph_shortest_path_engine_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 10 ns clock
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// result side: check, random back-pressure, watchdog
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		m_axis_tready <= ($urandom % 100) >= rx_idle_pct;
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog expired with %0d results outstanding",
				$time, sb.pending_hops.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// one request; valid stays high unless the next one idles
	task automatic send_request(input logic action, input logic [79:0] d);
		while (($urandom % 100) < tx_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= action;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(action, d);
		if (action == ACT_LOAD)
			loads_sent++;
	endtask

	function automatic logic [79:0] pack_node(input logic [4:0] idx, input logic [16:0] x,
		input logic [16:0] y, input logic [5:0] la, input logic [5:0] lb,
		input logic [5:0] lc, input logic [5:0] ld);
		return {7'b0, 5'($urandom), 5'($urandom), ld, lc, lb, la, y, x, idx};
	endfunction

	function automatic logic [79:0] pack_query(input logic [4:0] src, input logic [4:0] dst);
		return {7'b0, dst, src, 63'($urandom) ^ {31'($urandom), 32'($urandom)}};
	endfunction

	function automatic logic [16:0] rand_coord();
		return ($urandom % 4 == 0) ? 17'($urandom) : 17'($urandom_range(0, 2000));
	endfunction

	function automatic logic [5:0] rand_link();
		return ($urandom % 4 == 0) ? 6'd32 : 6'($urandom_range(0, 32));
	endfunction

	task automatic drain_results();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_hops.size() != 0)
			@(posedge clk);
	endtask

	// mostly node rewrites with random content, the rest queries
	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom % 100 < 60)
				send_request(ACT_LOAD, pack_node(5'($urandom), rand_coord(), rand_coord(),
					rand_link(), rand_link(), rand_link(), rand_link()));
			else
				send_request(ACT_QUERY, pack_query(5'($urandom), 5'($urandom)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// every node written first: a two-way chain, corners at the extremes
		for (int i = 0; i < 32; i++)
			send_request(ACT_LOAD, pack_node(5'(i),
				(i == 31) ? 17'h1FFFF : 17'(i * 1000), (i == 31) ? 17'h1FFFF : 17'(i * 37),
				(i < 31) ? 6'(i + 1) : 6'd32, (i > 0) ? 6'(i - 1) : 6'd32, 6'd32, 6'd32));
		// longest path both ways, source equals target, short hop
		send_request(ACT_QUERY, pack_query(5'd0, 5'd31));
		send_request(ACT_QUERY, pack_query(5'd31, 5'd0));
		send_request(ACT_QUERY, pack_query(5'd5, 5'd5));
		send_request(ACT_QUERY, pack_query(5'd3, 5'd4));
		// one-way cut: node 10 forward only, target behind it unreachable
		send_request(ACT_LOAD, pack_node(5'd10, 17'd10000, 17'd370, 6'd11, 6'd32, 6'd32, 6'd32));
		send_request(ACT_QUERY, pack_query(5'd10, 5'd9));
		// isolated node
		send_request(ACT_LOAD, pack_node(5'd20, 17'd0, 17'd0, 6'd32, 6'd32, 6'd32, 6'd32));
		send_request(ACT_QUERY, pack_query(5'd20, 5'd25));
		// zero-length edge between coincident nodes
		send_request(ACT_LOAD, pack_node(5'd12, 17'd11000, 17'd407, 6'd11, 6'd13, 6'd11, 6'd13));
		send_request(ACT_QUERY, pack_query(5'd13, 5'd11));
		send_request(ACT_QUERY, pack_query(5'd0, 5'd30));

		// hold off until every expected hop is back
		drain_results();

		random_phase(40);
		drain_results();
		tx_idle_pct = 62;
		rx_idle_pct = 24;
		random_phase(40);
		drain_results();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(40);

		drain_results();
		repeat (200) @(posedge clk);
		$display("covered %0d node loads and %0d queries, %0d results checked",
			loads_sent, sb.queries, sb.hops_checked);
		$display("idling on either side, both swapped and none; %0d results left over",
			sb.pending_hops.size());
		if (sb.errors == 0 && sb.pending_hops.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
